@@ sv/tdsmf_pkg.sv @@
// ----------------------------------------------------------------------------
// tdsmf_pkg
// shared constants, types and sequencer states of the dissolved-solids filter
// ----------------------------------------------------------------------------
`default_nettype none

package tdsmf_pkg;

    // sample ring
    localparam int SAMPLE_COUNT = 30;
    localparam int SAMPLE_W     = 10;
    localparam int IDX_W        = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);
    localparam bit MEDIAN_EVEN  = (SAMPLE_COUNT % 2) == 0;
    localparam int K_LOW        = MEDIAN_EVEN ? (SAMPLE_COUNT / 2 - 1) : ((SAMPLE_COUNT - 1) / 2);
    localparam int K_HIGH       = SAMPLE_COUNT / 2;

    // temperature register
    localparam int          TEMP_W      = 7;
    localparam logic [6:0]  TEMP_RESET  = 7'd25;
    localparam int          TEMP_OFFSET = 25;

    // conversion: c = median * 320 * 50 / (T + 25)
    localparam int VOLT_SCALE = 16000;
    localparam int NUM_W      = 24;
    localparam int DEN_W      = 8;
    localparam int C_W        = 20;
    localparam int C2_W       = 23;
    localparam int C3_W       = 26;
    localparam int FRAC_W     = 16;

    // cubic coefficients, Q10.16
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;
    localparam logic [MUL_W-1:0] K_CUBE   = 26'd8743813;
    localparam logic [MUL_W-1:0] K_SQUARE = 26'd16768041;
    localparam logic [MUL_W-1:0] K_LINEAR = 26'd56189911;

    localparam int PPM_W     = 16;
    localparam int PPM_SHIFT = 33;

    // register port
    localparam int          ADDR_W   = 3;
    localparam int          DATA_W   = 32;
    localparam logic [0:0]  REG_TEMP = 1'b0;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SELECT,
        ST_DIVIDE,
        ST_SQUARE,
        ST_CUBE,
        ST_TERM_CUBE,
        ST_TERM_LIN,
        ST_TERM_SQR,
        ST_OUTPUT
    } state_t;

endpackage

`default_nettype wire

@@ sv/tdsmf_if.sv @@
// ----------------------------------------------------------------------------
// tdsmf_if
// valid/ready channels for sample items and results
// ----------------------------------------------------------------------------
`default_nettype none

interface tdsmf_in_if;
    logic                           valid;
    logic                           ready;
    logic                           has_sample;
    logic [tdsmf_pkg::SAMPLE_W-1:0] adc_sample;
    logic                           report;

    modport source (output valid, has_sample, adc_sample, report, input ready);
    modport sink   (input valid, has_sample, adc_sample, report, output ready);
endinterface

interface tdsmf_out_if;
    logic                           valid;
    logic                           ready;
    logic [tdsmf_pkg::SAMPLE_W-1:0] median_code;
    logic [tdsmf_pkg::PPM_W-1:0]    tds_ppm;

    modport source (output valid, median_code, tds_ppm, input ready);
    modport sink   (input valid, median_code, tds_ppm, output ready);
endinterface

`default_nettype wire

@@ sv/tdsmf_ring_select.sv @@
// ----------------------------------------------------------------------------
// tdsmf_ring_select
// sample ring with a bit-serial radix median search, one entry per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tdsmf_ring_select (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [tdsmf_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic                           start,
    output logic                                done,
    output logic [tdsmf_pkg::SAMPLE_W-1:0]      median
);

    localparam int SW = tdsmf_pkg::SAMPLE_W;
    localparam int IW = tdsmf_pkg::IDX_W;
    localparam int CW = tdsmf_pkg::CNT_W;

    logic [SW-1:0] ring_reg [tdsmf_pkg::SAMPLE_COUNT];
    logic [IW-1:0] wpos_reg, wpos_next;
    logic          busy_reg, busy_next;
    logic          second_reg, second_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [SW-1:0] bit_sel_reg, bit_sel_next;
    logic [SW-1:0] mask_reg, mask_next;
    logic [SW-1:0] prefix_reg, prefix_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] first_reg, first_next;
    logic [SW-1:0] median_reg, median_next;
    logic          done_reg, done_next;

    logic [SW-1:0] entry;
    logic          hit;
    logic [CW-1:0] cnt_sum;
    logic [SW-1:0] prefix_new;
    logic [SW:0]   pair_sum;

    assign entry    = ring_reg[idx_reg];
    assign hit      = (((entry ^ prefix_reg) & mask_reg) == '0) && ((entry & bit_sel_reg) == '0);
    assign cnt_sum  = cnt_reg + CW'(hit);
    assign prefix_new = (k_reg < cnt_sum) ? prefix_reg : (prefix_reg | bit_sel_reg);
    assign pair_sum = {1'b0, first_reg} + {1'b0, prefix_new};

    always_comb
    begin
        wpos_next    = wpos_reg;
        busy_next    = busy_reg;
        second_next  = second_reg;
        idx_next     = idx_reg;
        bit_sel_next = bit_sel_reg;
        mask_next    = mask_reg;
        prefix_next  = prefix_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        first_next   = first_reg;
        median_next  = median_reg;
        done_next    = 1'b0;

        if (wr_en)
        begin
            if (wpos_reg == IW'(tdsmf_pkg::SAMPLE_COUNT - 1))
                wpos_next = '0;
            else
                wpos_next = wpos_reg + 1'b1;
        end

        if (start)
        begin
            busy_next    = 1'b1;
            second_next  = 1'b0;
            idx_next     = '0;
            bit_sel_next = {1'b1, {(SW-1){1'b0}}};
            mask_next    = '0;
            prefix_next  = '0;
            k_next       = CW'(tdsmf_pkg::K_LOW);
            cnt_next     = '0;
        end
        else if (busy_reg)
        begin
            if (idx_reg == IW'(tdsmf_pkg::SAMPLE_COUNT - 1))
            begin
                // one bit settled: keep 0 or take 1 and skip the entries whose bit is 0
                idx_next     = '0;
                cnt_next     = '0;
                prefix_next  = prefix_new;
                if (!(k_reg < cnt_sum))
                    k_next = k_reg - cnt_sum;
                bit_sel_next = bit_sel_reg >> 1;
                mask_next    = {1'b1, mask_reg[SW-1:1]};
                if (bit_sel_reg[0])
                begin
                    if (tdsmf_pkg::MEDIAN_EVEN && !second_reg)
                    begin
                        first_next   = prefix_new;
                        second_next  = 1'b1;
                        bit_sel_next = {1'b1, {(SW-1){1'b0}}};
                        mask_next    = '0;
                        prefix_next  = '0;
                        k_next       = CW'(tdsmf_pkg::K_HIGH);
                    end
                    else
                    begin
                        busy_next   = 1'b0;
                        done_next   = 1'b1;
                        median_next = tdsmf_pkg::MEDIAN_EVEN ? pair_sum[SW:1] : prefix_new;
                    end
                end
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                cnt_next = cnt_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tdsmf_pkg::SAMPLE_COUNT; i++)
                ring_reg[i] <= '0;
            wpos_reg    <= '0;
            busy_reg    <= 1'b0;
            second_reg  <= 1'b0;
            idx_reg     <= '0;
            bit_sel_reg <= '0;
            mask_reg    <= '0;
            prefix_reg  <= '0;
            k_reg       <= '0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
                ring_reg[wpos_reg] <= wr_data;
            wpos_reg    <= wpos_next;
            busy_reg    <= busy_next;
            second_reg  <= second_next;
            idx_reg     <= idx_next;
            bit_sel_reg <= bit_sel_next;
            mask_reg    <= mask_next;
            prefix_reg  <= prefix_next;
            k_reg       <= k_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        median_reg <= median_next;
    end

    assign done   = done_reg;
    assign median = median_reg;

endmodule

`default_nettype wire

@@ sv/tdsmf_serial_div.sv @@
// ----------------------------------------------------------------------------
// tdsmf_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tdsmf_serial_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tdsmf_pkg::div_req_t         req,
    output logic                             done,
    output logic [tdsmf_pkg::NUM_W-1:0]      quotient
);

    localparam int NW = tdsmf_pkg::NUM_W;
    localparam int DW = tdsmf_pkg::DEN_W;
    localparam int KW = $clog2(NW);

    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = req.num;
            cnt_next  = KW'(NW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ sv/tdsmf_serial_mul.sv @@
// ----------------------------------------------------------------------------
// tdsmf_serial_mul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tdsmf_serial_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tdsmf_pkg::mul_req_t         req,
    output logic                             done,
    output logic [tdsmf_pkg::PROD_W-1:0]     product
);

    localparam int MW = tdsmf_pkg::MUL_W;
    localparam int PW = tdsmf_pkg::PROD_W;
    localparam int KW = $clog2(MW);

    logic [PW-1:0] a_reg, a_next;
    logic [MW-1:0] b_reg, b_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = PW'(req.a);
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = KW'(MW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

@@ sv/tds_median_filter_converter_top.sv @@
// ----------------------------------------------------------------------------
// tds_median_filter_converter_top
// median filter over the sample ring and cubic ppm conversion
// ----------------------------------------------------------------------------
// latency of a report from the input transfer to a valid result is set mostly
//   by the bit-serial median search, which visits one entry a cycle
// throughput: items without a report transfer every cycle; with a report the
//   next item is taken once the result has moved to the output register
// reset: ring cleared to zero, write position zero, water temperature 25
`default_nettype none

module tds_median_filter_converter_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    tdsmf_in_if.sink                           in_ch,
    tdsmf_out_if.source                        out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tdsmf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [tdsmf_pkg::DATA_W-1:0]  pwdata,
    output logic [tdsmf_pkg::DATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int SW = tdsmf_pkg::SAMPLE_W;
    localparam int PW = tdsmf_pkg::PROD_W;
    localparam int MW = tdsmf_pkg::MUL_W;
    localparam int FW = tdsmf_pkg::FRAC_W;
    localparam int HW = PW - tdsmf_pkg::PPM_SHIFT;

    tdsmf_pkg::state_t state_reg, state_next;

    logic [tdsmf_pkg::TEMP_W-1:0] temp_reg;
    logic                         out_valid_reg;
    logic [SW-1:0]                out_median_reg;
    logic [tdsmf_pkg::PPM_W-1:0]  out_ppm_reg;
    logic [SW-1:0]                median_reg;
    logic [tdsmf_pkg::C_W-1:0]    c_reg;
    logic [tdsmf_pkg::C2_W-1:0]   c2_reg;
    logic [PW-1:0]                pos_reg;
    logic [tdsmf_pkg::PPM_W-1:0]  ppm_reg;

    logic in_xfer;
    logic out_free;
    logic cfg_write;

    // sub-unit handshakes
    logic                             sel_start;
    logic                             sel_done;
    logic [SW-1:0]                    sel_median;
    tdsmf_pkg::div_req_t              div_req;
    logic                             div_done;
    logic [tdsmf_pkg::NUM_W-1:0]      div_quo;
    tdsmf_pkg::mul_req_t              mul_req;
    logic                             mul_done;
    logic [PW-1:0]                    mul_prod;

    // final stage of the cubic: clamp negative sums, drop Q32 and halve, saturate
    logic [PW-1:0] diff;
    logic [HW-1:0] ppm_hi;
    logic [tdsmf_pkg::PPM_W-1:0] ppm_value;

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign diff   = pos_reg - mul_prod;
    assign ppm_hi = diff[PW-1:tdsmf_pkg::PPM_SHIFT];
    always_comb
    begin
        if (mul_prod >= pos_reg)
            ppm_value = '0;
        else if (ppm_hi[HW-1:tdsmf_pkg::PPM_W] != '0)
            ppm_value = '1;
        else
            ppm_value = ppm_hi[tdsmf_pkg::PPM_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdsmf_pkg::ST_IDLE:
                if (in_xfer && in_ch.report)
                    state_next = tdsmf_pkg::ST_SELECT;
            tdsmf_pkg::ST_SELECT:
                if (sel_done)
                    state_next = tdsmf_pkg::ST_DIVIDE;
            tdsmf_pkg::ST_DIVIDE:
                if (div_done)
                    state_next = tdsmf_pkg::ST_SQUARE;
            tdsmf_pkg::ST_SQUARE:
                if (mul_done)
                    state_next = tdsmf_pkg::ST_CUBE;
            tdsmf_pkg::ST_CUBE:
                if (mul_done)
                    state_next = tdsmf_pkg::ST_TERM_CUBE;
            tdsmf_pkg::ST_TERM_CUBE:
                if (mul_done)
                    state_next = tdsmf_pkg::ST_TERM_LIN;
            tdsmf_pkg::ST_TERM_LIN:
                if (mul_done)
                    state_next = tdsmf_pkg::ST_TERM_SQR;
            tdsmf_pkg::ST_TERM_SQR:
                if (mul_done)
                    state_next = tdsmf_pkg::ST_OUTPUT;
            tdsmf_pkg::ST_OUTPUT:
                if (out_free)
                    state_next = tdsmf_pkg::ST_IDLE;
            default:
                state_next = tdsmf_pkg::ST_IDLE;
        endcase
    end

    // unit launches: each unit starts as the one before it finishes
    always_comb
    begin
        sel_start     = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = tdsmf_pkg::NUM_W'(32'(sel_median) * tdsmf_pkg::VOLT_SCALE);
        div_req.den   = tdsmf_pkg::DEN_W'(temp_reg) + tdsmf_pkg::DEN_W'(tdsmf_pkg::TEMP_OFFSET);
        mul_req.start = 1'b0;
        mul_req.a     = MW'(c_reg);
        mul_req.b     = MW'(c_reg);
        case (state_reg)
            tdsmf_pkg::ST_IDLE:
                sel_start = in_xfer && in_ch.report;
            tdsmf_pkg::ST_SELECT:
                div_req.start = sel_done;
            tdsmf_pkg::ST_DIVIDE:
            begin
                // c times c
                mul_req.start = div_done;
                mul_req.a     = MW'(div_quo[tdsmf_pkg::C_W-1:0]);
                mul_req.b     = MW'(div_quo[tdsmf_pkg::C_W-1:0]);
            end
            tdsmf_pkg::ST_SQUARE:
            begin
                // c2 times c
                mul_req.start = mul_done;
                mul_req.a     = MW'(mul_prod[tdsmf_pkg::C2_W+FW-1:FW]);
            end
            tdsmf_pkg::ST_CUBE:
            begin
                mul_req.start = mul_done;
                mul_req.a     = tdsmf_pkg::K_CUBE;
                mul_req.b     = MW'(mul_prod[tdsmf_pkg::C3_W+FW-1:FW]);
            end
            tdsmf_pkg::ST_TERM_CUBE:
            begin
                mul_req.start = mul_done;
                mul_req.a     = tdsmf_pkg::K_LINEAR;
            end
            tdsmf_pkg::ST_TERM_LIN:
            begin
                mul_req.start = mul_done;
                mul_req.a     = tdsmf_pkg::K_SQUARE;
                mul_req.b     = MW'(c2_reg);
            end
            default:
                mul_req.start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdsmf_pkg::ST_IDLE;
            temp_reg      <= tdsmf_pkg::TEMP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && paddr[tdsmf_pkg::ADDR_W-1:2] == tdsmf_pkg::REG_TEMP)
                temp_reg <= pwdata[tdsmf_pkg::TEMP_W-1:0];
            if (state_reg == tdsmf_pkg::ST_OUTPUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath holding registers
    always_ff @(posedge clk)
    begin
        if (state_reg == tdsmf_pkg::ST_SELECT && sel_done)
            median_reg <= sel_median;
        if (state_reg == tdsmf_pkg::ST_DIVIDE && div_done)
            c_reg <= div_quo[tdsmf_pkg::C_W-1:0];
        if (state_reg == tdsmf_pkg::ST_SQUARE && mul_done)
            c2_reg <= mul_prod[tdsmf_pkg::C2_W+FW-1:FW];
        if (state_reg == tdsmf_pkg::ST_TERM_CUBE && mul_done)
            pos_reg <= mul_prod;
        if (state_reg == tdsmf_pkg::ST_TERM_LIN && mul_done)
            pos_reg <= pos_reg + mul_prod;
        if (state_reg == tdsmf_pkg::ST_TERM_SQR && mul_done)
            ppm_reg <= ppm_value;
        if (state_reg == tdsmf_pkg::ST_OUTPUT && out_free)
        begin
            out_median_reg <= median_reg;
            out_ppm_reg    <= ppm_reg;
        end
    end

    tdsmf_ring_select u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_xfer && in_ch.has_sample),
        .wr_data (in_ch.adc_sample),
        .start   (sel_start),
        .done    (sel_done),
        .median  (sel_median)
    );

    tdsmf_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    tdsmf_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    // items transfer only while the sequencer is idle
    assign in_ch.ready = (state_reg == tdsmf_pkg::ST_IDLE);

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.median_code = out_median_reg;
    assign out_ch.tds_ppm     = out_ppm_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[tdsmf_pkg::ADDR_W-1:2] == tdsmf_pkg::REG_TEMP)
                    ? tdsmf_pkg::DATA_W'(temp_reg) : '0;

    a_rise_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tdsmf_pkg::ST_OUTPUT))
        else $error("result raised outside the output step");

    a_sel_done_in_select: assert property (@(posedge clk) disable iff (!rst_n)
        sel_done |-> state_reg == tdsmf_pkg::ST_SELECT)
        else $error("median search finished outside its step");

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == tdsmf_pkg::ST_DIVIDE)
        else $error("divider finished outside its step");

    a_mul_idle_outside: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == tdsmf_pkg::ST_SQUARE || state_reg == tdsmf_pkg::ST_CUBE
                      || state_reg == tdsmf_pkg::ST_TERM_CUBE
                      || state_reg == tdsmf_pkg::ST_TERM_LIN
                      || state_reg == tdsmf_pkg::ST_TERM_SQR))
        else $error("multiplier finished outside the cubic steps");

endmodule

`default_nettype wire
